### rtl/acrt_pkg.sv
package acrt_pkg;

    localparam int unsigned FRAC_BITS  = 16;
    localparam int unsigned RATIO_W    = FRAC_BITS + 1;
    localparam int unsigned FACTOR_W   = FRAC_BITS + 2;
    localparam int unsigned WIDTH_W    = 32;
    localparam int unsigned WINDOW_W   = 16;
    localparam int unsigned TALLY_W    = 16;
    localparam int unsigned PROD_W     = WIDTH_W + FACTOR_W;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [RATIO_W-1:0] Q_ONE = RATIO_W'(1) << FRAC_BITS;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_FLOOR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WIDTH_CEILING = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_RATIO  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_START_WIDTH   = 3'd4;

    // register reset values
    localparam logic [WINDOW_W-1:0] RST_WINDOW_LENGTH = 16'd100;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH_FLOOR   = 32'd0;
    localparam logic [WIDTH_W-1:0]  RST_WIDTH_CEILING = 32'd65536;
    localparam logic [RATIO_W-1:0]  RST_TARGET_RATIO  = 17'd32768;
    localparam logic [WIDTH_W-1:0]  RST_START_WIDTH   = 32'd32768;

    // result tdata layout, lowest bit up
    localparam int unsigned OUT_WIDTH_LO = 0;
    localparam int unsigned OUT_RATIO_LO = OUT_WIDTH_LO + WIDTH_W;
    localparam int unsigned OUT_ACC_LO   = OUT_RATIO_LO + RATIO_W;
    localparam int unsigned OUT_REJ_LO   = OUT_ACC_LO + TALLY_W;
    localparam int unsigned OUT_BITS     = OUT_REJ_LO + TALLY_W;
    localparam int unsigned OUT_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [TALLY_W-1:0] rejected_tally;
        logic [TALLY_W-1:0] accepted_tally;
        logic [RATIO_W-1:0] last_ratio;
        logic [WIDTH_W-1:0] step_width;
    } result_t;

    typedef struct packed {
        logic               done;
        logic [RATIO_W-1:0] quotient;
    } div_status_t;

endpackage

### rtl/acceptance_ratio_stepwidth_tuner_core.sv
// Acceptance-ratio step width tuner.
// s_ channel: one trial outcome per transfer (tdata bit 0: 1 accepted, 0 rejected).
// m_ channel: one result per input transfer; tdata carries step width, ratio of the
//   last closed window and both tallies, tuser flags a transfer that closed a window.
// cfg channel: register writes (index, data), always ready; write only while idle.
//   A start_width write loads the working step width at once.
// Sequence: an outcome that does not close a window is presented in the cycle after
//   acceptance. An outcome that closes a window runs 17 iterations of
//   the shared compare-subtract unit in the ratio divider (one quotient bit each,
//   the first in the accepting cycle), then forms the scale factor, does the width
//   multiply and finally saturates and updates the width.
// Throughput: one outcome per cycle inside a window while the receiver keeps up.
// s_tready is low while a window close is in progress and while a finished result
//   is held in the output register and the receiver stalls; m_ holds its transfer
//   stable until m_tready.
// Reset (aresetn low, synchronous) restores all register defaults, clears both
//   counts and the last ratio, and loads the working width from start_width.
module acceptance_ratio_stepwidth_tuner_core #(
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [7:0]                          s_tdata,   // [0] was_accepted
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [31:0] step_width, [48:32] last_ratio, [64:49] accepted_tally,
    // [80:65] rejected_tally, rest zero
    output logic [acrt_pkg::OUT_TDATA_W-1:0]    m_tdata,
    output logic [0:0]                          m_tuser,   // [0] adjusted
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [acrt_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [acrt_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam int unsigned CW = ((COUNT_BITS > acrt_pkg::WINDOW_W) ?
                                  COUNT_BITS : acrt_pkg::WINDOW_W) + 1;
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg, state_next;

    logic [acrt_pkg::WINDOW_W-1:0] window_reg;
    logic [acrt_pkg::WIDTH_W-1:0]  floor_reg;
    logic [acrt_pkg::WIDTH_W-1:0]  ceil_reg;
    logic [acrt_pkg::RATIO_W-1:0]  target_reg;

    logic [COUNT_BITS-1:0]          acc_reg, acc_next;
    logic [COUNT_BITS-1:0]          rej_reg, rej_next;
    logic [acrt_pkg::WIDTH_W-1:0]   width_reg, width_next;
    logic [acrt_pkg::RATIO_W-1:0]   ratio_reg, ratio_next;
    logic [acrt_pkg::FACTOR_W-1:0]  factor_reg, factor_next;
    logic                           shrink_reg, shrink_next;
    logic [acrt_pkg::PROD_W-1:0]    prod_reg, prod_next;

    acrt_pkg::result_t              res_reg, res_next;
    logic                           adj_reg, adj_next;
    logic                           mvalid_reg, mvalid_next;

    logic                           s_fire;
    logic                           cfg_fire;
    logic [COUNT_BITS-1:0]          acc_inc;
    logic [COUNT_BITS-1:0]          rej_inc;
    logic [COUNT_BITS:0]            total;
    logic [CW-1:0]                  limit;
    logic                           closes;
    logic                           div_start;
    logic [acrt_pkg::RATIO_W-1:0]   target_eff;
    logic [acrt_pkg::WIDTH_W+1:0]   grown;
    logic [acrt_pkg::WIDTH_W-1:0]   width_adj;
    acrt_pkg::div_status_t          div_status;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid;
    assign s_tready  = (state_reg == ST_IDLE) && (!mvalid_reg || m_tready);
    assign s_fire    = s_tvalid && s_tready;

    always_comb begin
        acc_inc = acc_reg;
        rej_inc = rej_reg;
        if (s_tdata[0]) begin
            if (acc_reg != CMAX) acc_inc = acc_reg + COUNT_BITS'(1);
        end else begin
            if (rej_reg != CMAX) rej_inc = rej_reg + COUNT_BITS'(1);
        end
        total = {1'b0, acc_inc} + {1'b0, rej_inc};
        limit = (CW'(window_reg) < CW'(CMAX)) ? CW'(window_reg) : CW'(CMAX);
        closes = CW'(total) >= limit;
        div_start = s_fire && closes;
        target_eff = (target_reg > acrt_pkg::Q_ONE) ? acrt_pkg::Q_ONE : target_reg;
    end

    acrt_div #(
        .W (COUNT_BITS)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (acc_inc),
        .divisor  (total[COUNT_BITS-1:0]),
        .status   (div_status)
    );

    always_comb begin
        grown = prod_reg[acrt_pkg::PROD_W-1:acrt_pkg::FRAC_BITS];
        width_adj = width_reg;
        if (shrink_reg) begin
            if (width_reg > floor_reg) width_adj = grown[acrt_pkg::WIDTH_W-1:0];
        end else if (width_reg >= ceil_reg) begin
            width_adj = ceil_reg;
        end else if (grown >= (acrt_pkg::WIDTH_W+2)'(ceil_reg)) begin
            width_adj = ceil_reg;
        end else begin
            width_adj = grown[acrt_pkg::WIDTH_W-1:0];
        end
    end

    always_comb begin
        state_next  = state_reg;
        acc_next    = acc_reg;
        rej_next    = rej_reg;
        width_next  = width_reg;
        ratio_next  = ratio_reg;
        factor_next = factor_reg;
        shrink_next = shrink_reg;
        prod_next   = prod_reg;
        res_next    = res_reg;
        adj_next    = adj_reg;
        mvalid_next = mvalid_reg && !m_tready;

        if (cfg_fire && cfg_index == acrt_pkg::CFG_START_WIDTH) begin
            width_next = cfg_data;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    if (closes) begin
                        state_next = ST_DIV;
                    end else begin
                        acc_next    = acc_inc;
                        rej_next    = rej_inc;
                        res_next.step_width     = width_reg;
                        res_next.last_ratio     = ratio_reg;
                        res_next.accepted_tally = acrt_pkg::TALLY_W'(acc_inc);
                        res_next.rejected_tally = acrt_pkg::TALLY_W'(rej_inc);
                        adj_next    = 1'b0;
                        mvalid_next = 1'b1;
                    end
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    ratio_next  = div_status.quotient;
                    factor_next = {1'b0, acrt_pkg::Q_ONE}
                                + {1'b0, div_status.quotient} - {1'b0, target_eff};
                    shrink_next = div_status.quotient < target_eff;
                    state_next  = ST_MUL;
                end
            end
            ST_MUL: begin
                prod_next  = acrt_pkg::PROD_W'(width_reg) * acrt_pkg::PROD_W'(factor_reg);
                state_next = ST_FIN;
            end
            ST_FIN: begin
                width_next  = width_adj;
                acc_next    = '0;
                rej_next    = '0;
                res_next.step_width     = width_adj;
                res_next.last_ratio     = ratio_reg;
                res_next.accepted_tally = '0;
                res_next.rejected_tally = '0;
                adj_next    = 1'b1;
                mvalid_next = 1'b1;
                state_next  = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            window_reg <= acrt_pkg::RST_WINDOW_LENGTH;
            floor_reg  <= acrt_pkg::RST_WIDTH_FLOOR;
            ceil_reg   <= acrt_pkg::RST_WIDTH_CEILING;
            target_reg <= acrt_pkg::RST_TARGET_RATIO;
            acc_reg    <= '0;
            rej_reg    <= '0;
            width_reg  <= acrt_pkg::RST_START_WIDTH;
            ratio_reg  <= '0;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            acc_reg    <= acc_next;
            rej_reg    <= rej_next;
            width_reg  <= width_next;
            ratio_reg  <= ratio_next;
            mvalid_reg <= mvalid_next;
            if (cfg_fire) begin
                unique case (cfg_index)
                    acrt_pkg::CFG_WINDOW_LENGTH:
                        window_reg <= cfg_data[acrt_pkg::WINDOW_W-1:0];
                    acrt_pkg::CFG_WIDTH_FLOOR:   floor_reg  <= cfg_data;
                    acrt_pkg::CFG_WIDTH_CEILING: ceil_reg   <= cfg_data;
                    acrt_pkg::CFG_TARGET_RATIO:
                        target_reg <= cfg_data[acrt_pkg::RATIO_W-1:0];
                    // start width goes straight into the working width
                    acrt_pkg::CFG_START_WIDTH: ;
                    default: ;
                endcase
            end
        end
        factor_reg <= factor_next;
        shrink_reg <= shrink_next;
        prod_reg   <= prod_next;
        res_reg    <= res_next;
        adj_reg    <= adj_next;
    end

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = acrt_pkg::OUT_TDATA_W'(res_reg);
    assign m_tuser  = adj_reg;

endmodule

### rtl/acrt_div.sv
module acrt_div #(
    parameter int unsigned W = 16
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  logic [W-1:0]         dividend,
    input  logic [W-1:0]         divisor,
    output acrt_pkg::div_status_t status
);

    localparam int unsigned STEP_W = $clog2(acrt_pkg::FRAC_BITS + 1);

    logic [W-1:0]                   rem_reg, rem_next;
    logic [W-1:0]                   dvs_reg, dvs_next;
    logic [acrt_pkg::RATIO_W-1:0]   quot_reg, quot_next;
    logic [STEP_W-1:0]              cnt_reg, cnt_next;
    logic                           busy_reg, busy_next;
    logic                           done_reg, done_next;

    logic [W:0]   op_a;
    logic [W:0]   op_b;
    logic [W+1:0] diff;
    logic         fits;

    // single compare-subtract shared by the first quotient bit and the fraction steps
    always_comb begin
        op_a = start ? {1'b0, dividend} : {rem_reg, 1'b0};
        op_b = start ? {1'b0, divisor} : {1'b0, dvs_reg};
        diff = {1'b0, op_a} - {1'b0, op_b};
        fits = !diff[W+1];
    end

    always_comb begin
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quot_next = quot_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next  = fits ? diff[W-1:0] : dividend;
            dvs_next  = divisor;
            quot_next = {{(acrt_pkg::RATIO_W-1){1'b0}}, fits};
            cnt_next  = STEP_W'(acrt_pkg::FRAC_BITS);
            busy_next = 1'b1;
        end else if (busy_reg) begin
            // remainder stays below the divisor, so the low W bits hold it
            rem_next  = fits ? diff[W-1:0] : op_a[W-1:0];
            quot_next = {quot_reg[acrt_pkg::RATIO_W-2:0], fits};
            cnt_next  = cnt_reg - STEP_W'(1);
            if (cnt_reg == STEP_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg  <= rem_next;
        dvs_reg  <= dvs_next;
        quot_reg <= quot_next;
    end

    assign status.done     = done_reg;
    assign status.quotient = quot_reg;

endmodule

### rtl/acrt_checker.sv
module acrt_checker (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [acrt_pkg::OUT_TDATA_W-1:0] m_tdata,
    input logic [0:0]                       m_tuser
);

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result transfer changed");

    // no new outcome is taken while an untaken result still sits in the output
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid || m_tready)
        else $error("input ready while output register is blocked");

    // a window close leaves both tallies cleared
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |->
            m_tdata[acrt_pkg::OUT_BITS-1:acrt_pkg::OUT_ACC_LO] == '0)
        else $error("tallies not cleared on window close");

    // ratio never exceeds one
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |->
            m_tdata[acrt_pkg::OUT_ACC_LO-1:acrt_pkg::OUT_RATIO_LO] <= acrt_pkg::Q_ONE)
        else $error("ratio above one");

endmodule

bind acceptance_ratio_stepwidth_tuner_core acrt_checker u_acrt_checker (.*);
